// File: rtl/core/rtfd_pkg.sv
// Shared constants and types for the tag frame deduplicator.
package rtfd_pkg;

  localparam int CMD_W  = 2;
  localparam int BYTE_W = 8;
  localparam int HOLD_W = 16;
  localparam int TICK_W = 17;
  localparam int CFG_W  = 16;
  localparam int CFG_IDX_W = 2;

  // Command codes of an input item.
  localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BYTE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_IDLE = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVITY = 2'd1;

  localparam logic [HOLD_W-1:0] HOLDOFF_RESET = 16'd150;

  // Framing bytes.
  localparam logic [BYTE_W-1:0] CHAR_STX = 8'h02;
  localparam logic [BYTE_W-1:0] CHAR_ETX = 8'h03;
  localparam logic [BYTE_W-1:0] CHAR_LF  = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_CR  = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_NUL = 8'h00;

  localparam logic [TICK_W-1:0] TICK_MAX = 17'h1FFFF;

  typedef struct packed {
    logic tick;
    logic restart;
  } rtfd_timer_ctl_t;

endpackage

// File: rtl/core/rtfd_if.sv
// Handshake channel interfaces for input items and result items.
interface rtfd_in_if;
  import rtfd_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output command, output rx_byte, input ready);
  modport sink (input valid, input command, input rx_byte, output ready);
endinterface

interface rtfd_out_if #(
  parameter int POS_W = 5
);
  import rtfd_pkg::*;
  logic              valid;
  logic              ready;
  logic              byte_taken;
  logic              new_tag;
  logic              char_valid;
  logic [BYTE_W-1:0] tag_char;
  logic [POS_W-1:0]  char_position;
  logic              last;
  logic              reader_reset_pulse;
  logic              activity;

  modport source (
    output valid, output byte_taken, output new_tag, output char_valid,
    output tag_char, output char_position, output last,
    output reader_reset_pulse, output activity, input ready
  );
  modport sink (
    input valid, input byte_taken, input new_tag, input char_valid,
    input tag_char, input char_position, input last,
    input reader_reset_pulse, input activity, output ready
  );
endinterface

// File: rtl/core/rtfd_holdoff_timer.sv
// Saturating tick counter and holdoff window compare.
module rtfd_holdoff_timer
  import rtfd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  rtfd_timer_ctl_t   ctl,
  input  logic [HOLD_W-1:0] holdoff,
  output logic              open
);

  logic [TICK_W-1:0] elapsed;

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed <= '0;
    end else if (ctl.restart) begin
      elapsed <= '0;
    end else if (ctl.tick && elapsed != TICK_MAX) begin
      elapsed <= elapsed + TICK_W'(1);
    end
  end

  // Bytes pass once the count exceeds the holdoff.
  assign open = elapsed > {1'b0, holdoff};

endmodule

// File: rtl/core/rfid_tag_frame_deduplicator.sv
// Top level of the tag frame deduplicator: framing, tag compare and report sequencer.
//
//   channel  dir  handshake          payload
//   req      in   valid / ready      command, rx_byte
//   rsp      out  valid / ready      byte_taken, new_tag, char_valid, tag_char,
//                                    char_position, last, reader_reset_pulse, activity
//   cfg      in   cfg_we only        cfg_index, cfg_data
//
// A tick, idle poll or ordinary byte loads its status item into the output register
// at the accepting edge. A closing byte walks the tag store through the single
// compare unit, one stored character at a time (registered memory read, then
// compare), and a report then reads and emits each character in turn, waiting
// whenever the output register is full.
// Reset is synchronous and clears control state; the tag memories need none.
// req.ready drops while a frame close is in progress or the output register is full.
module rfid_tag_frame_deduplicator
  import rtfd_pkg::*;
#(
  parameter int TAG_SLOTS = 20
) (
  input  logic                 clk,
  input  logic                 rst,
  rtfd_in_if.sink              req,
  rtfd_out_if.source           rsp,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int SLOT_W = $clog2(TAG_SLOTS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_PUSH,
    S_EMIT_RD,
    S_EMIT_OUT
  } state_t;

  state_t state;

  // Configuration.
  logic [HOLD_W-1:0] holdoff;
  logic              act_en;

  // Framing and tag state.
  logic [SLOT_W-1:0] write_slot;
  logic              in_frame;
  logic [SLOT_W-1:0] prev_len;
  logic              activity_flag;

  // Sequencer scratch.
  logic [SLOT_W-1:0] idx;
  logic              differ;
  logic              push_report;

  // Tag memories with registered reads.
  logic [BYTE_W-1:0] tag_mem  [TAG_SLOTS];
  logic [BYTE_W-1:0] prev_mem [TAG_SLOTS];
  logic [BYTE_W-1:0] tag_q;
  logic [BYTE_W-1:0] prev_q;

  // Output register.
  logic              out_valid;
  logic              out_taken;
  logic              out_new;
  logic              out_cvalid;
  logic [BYTE_W-1:0] out_char;
  logic [SLOT_W-1:0] out_pos;
  logic              out_last;
  logic              out_pulse;
  logic              out_act;

  rtfd_timer_ctl_t timer_ctl;
  logic            open;

  logic slot_free;
  logic accept;
  logic is_byte;
  logic byte_ok;
  logic store_we;
  logic scan_more;
  logic differ_final;
  logic emit_last;
  logic activity_next;
  logic out_load;

  assign slot_free = !out_valid || rsp.ready;
  assign req.ready = (state == S_IDLE) && slot_free;
  assign accept    = req.valid && req.ready;
  assign is_byte   = req.command == CMD_BYTE;
  assign byte_ok   = accept && is_byte && open;

  // Store every in-frame byte that is not a framing or line-end character.
  assign store_we = byte_ok && in_frame &&
                    req.rx_byte != CHAR_STX && req.rx_byte != CHAR_ETX &&
                    req.rx_byte != CHAR_LF && req.rx_byte != CHAR_CR;

  // Tag ends at the write slot or the first zero byte.
  assign scan_more    = (idx < write_slot) && (tag_q != CHAR_NUL);
  assign differ_final = differ || (idx != prev_len);
  assign emit_last    = ({1'b0, idx} + (SLOT_W + 1)'(1)) == {1'b0, prev_len};

  assign activity_next = activity_flag || (byte_ok && act_en);

  // A result enters the output register on a status load, a push or an emit step;
  // a closing byte holds its result back until the compare finishes.
  assign out_load = (state == S_IDLE && accept && !(byte_ok && req.rx_byte == CHAR_ETX)) ||
                    ((state == S_PUSH || state == S_EMIT_OUT) && slot_free);

  assign timer_ctl.tick    = accept && req.command == CMD_TICK;
  assign timer_ctl.restart = (state == S_SCAN_CHK) && !scan_more && differ_final;

  rtfd_holdoff_timer u_timer (
    .clk     (clk),
    .rst     (rst),
    .ctl     (timer_ctl),
    .holdoff (holdoff),
    .open    (open)
  );

  always_ff @(posedge clk) begin
    if (store_we) begin
      tag_mem[write_slot] <= req.rx_byte;
    end
    tag_q <= tag_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT_OUT && slot_free) begin
      prev_mem[idx] <= tag_q;
    end
    prev_q <= prev_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      holdoff       <= HOLDOFF_RESET;
      act_en        <= 1'b0;
      write_slot    <= '0;
      in_frame      <= 1'b0;
      prev_len      <= '0;
      activity_flag <= 1'b0;
      idx           <= '0;
      differ        <= 1'b0;
      push_report   <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_HOLDOFF:  holdoff <= cfg_data[HOLD_W-1:0];
          CFG_ACTIVITY: act_en  <= cfg_data[0];
          default: ;
        endcase
      end

      // Load a new result, or drop the held one once the sink takes it.
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            activity_flag <= activity_next;
            // Status item by default.
            out_taken  <= byte_ok;
            out_new    <= 1'b0;
            out_cvalid <= 1'b0;
            out_char   <= '0;
            out_pos    <= '0;
            out_last   <= 1'b1;
            out_pulse  <= 1'b0;
            out_act    <= activity_next;
            if (req.command == CMD_IDLE && open) begin
              prev_len <= '0;
            end
            if (byte_ok) begin
              priority if (req.rx_byte == CHAR_ETX) begin
                // Hold the result until the compare finishes.
                idx       <= '0;
                differ    <= 1'b0;
                state     <= S_SCAN_RD;
              end else if (req.rx_byte == CHAR_STX) begin
                in_frame   <= 1'b1;
                write_slot <= '0;
              end else if (store_we) begin
                if (write_slot == SLOT_W'(TAG_SLOTS - 1)) begin
                  write_slot <= '0;
                end else begin
                  write_slot <= write_slot + SLOT_W'(1);
                end
              end
            end
          end
        end

        S_SCAN_RD: begin
          state <= S_SCAN_CHK;
        end

        S_SCAN_CHK: begin
          if (scan_more) begin
            if (idx < prev_len && tag_q != prev_q) begin
              differ <= 1'b1;
            end
            idx   <= idx + SLOT_W'(1);
            state <= S_SCAN_RD;
          end else begin
            write_slot  <= '0;
            in_frame    <= 1'b0;
            push_report <= differ_final;
            if (differ_final) begin
              prev_len <= idx;
            end
            if (differ_final && idx != '0) begin
              idx   <= '0;
              state <= S_EMIT_RD;
            end else begin
              state <= S_PUSH;
            end
          end
        end

        S_PUSH: begin
          // Status item, or the report of an empty tag.
          if (slot_free) begin
            out_taken  <= 1'b1;
            out_new    <= push_report;
            out_cvalid <= 1'b0;
            out_char   <= '0;
            out_pos    <= '0;
            out_last   <= 1'b1;
            out_pulse  <= push_report;
            out_act    <= activity_flag;
            state      <= S_IDLE;
          end
        end

        S_EMIT_RD: begin
          state <= S_EMIT_OUT;
        end

        S_EMIT_OUT: begin
          if (slot_free) begin
            out_taken  <= 1'b1;
            out_new    <= 1'b1;
            out_cvalid <= 1'b1;
            out_char   <= tag_q;
            out_pos    <= idx;
            out_last   <= emit_last;
            out_pulse  <= emit_last;
            out_act    <= activity_flag;
            if (emit_last) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx + SLOT_W'(1);
              state <= S_EMIT_RD;
            end
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid              = out_valid;
  assign rsp.byte_taken         = out_taken;
  assign rsp.new_tag            = out_new;
  assign rsp.char_valid         = out_cvalid;
  assign rsp.tag_char           = out_char;
  assign rsp.char_position      = out_pos;
  assign rsp.last               = out_last;
  assign rsp.reader_reset_pulse = out_pulse;
  assign rsp.activity           = out_act;

endmodule

// File: tb/sv/tb_rfid_tag_frame_deduplicator.sv
// Self-checking testbench for the tag frame deduplicator: directed cases, random framed traffic.
`timescale 1ns / 1ps

module tb_rfid_tag_frame_deduplicator;
  import rtfd_pkg::*;

  // The fourth command value and the register indexes past the list have no name in the
  // package; the block must treat them as no-ops.
  localparam logic [CMD_W-1:0]     CMD_UNUSED   = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3  = 2'd3;
  localparam int                   SLOTS        = 20;
  localparam int                   QUIET_LIMIT  = 5000;
  localparam int                   LONG_STALL   = 400;

  typedef logic [BYTE_W-1:0] tag_bytes_t[$];

  typedef struct packed {
    logic              byte_taken;
    logic              new_tag;
    logic              char_valid;
    logic [BYTE_W-1:0] tag_char;
    logic [4:0]        char_position;
    logic              last;
    logic              reader_reset_pulse;
    logic              activity;
  } tag_result_t;

  // Tracks framing, tag memory and holdoff for every accepted item and keeps the
  // queue of result items the block still owes.
  class tag_report_tracker;
    bit [BYTE_W-1:0] frame_bytes [SLOTS];
    bit [BYTE_W-1:0] shown_tag [SLOTS];
    bit [4:0]        shown_len;
    bit [4:0]        slot;
    bit              framing;
    bit [TICK_W-1:0] ticks_since_report;
    bit              active;
    bit [HOLD_W-1:0] holdoff;
    bit              active_enable;
    tag_result_t     owed[$];
    int unsigned     errors, n_items, n_refused, n_results, n_reports, n_empty;

    function new();
      holdoff = HOLDOFF_RESET;
      foreach (frame_bytes[i]) begin
        frame_bytes[i] = '0;
        shown_tag[i] = '0;
      end
    endfunction

    function void configure(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_HOLDOFF:  holdoff = data;
        CFG_ACTIVITY: active_enable = data[0];
        default: ;
      endcase
    endfunction

    function bit gate_open();
      return ticks_since_report > {1'b0, holdoff};
    endfunction

    function int outstanding();
      return owed.size();
    endfunction

    function void owe(bit taken, bit fresh, bit valid, bit [BYTE_W-1:0] ch, bit [4:0] pos,
                      bit fin, bit pulse);
      tag_result_t r;
      r.byte_taken = taken;
      r.new_tag = fresh;
      r.char_valid = valid;
      r.tag_char = ch;
      r.char_position = pos;
      r.last = fin;
      r.reader_reset_pulse = pulse;
      r.activity = active;
      owed.push_back(r);
    endfunction

    // Close the frame; return 1 if the tag differed and a report was owed.
    function bit close_tag();
      bit [4:0] len;
      bit       differ;
      len = 0;
      while (len < slot && frame_bytes[len] != CHAR_NUL) len++;
      differ = (len != shown_len);
      for (int i = 0; i < len; i++)
        if (frame_bytes[i] != shown_tag[i]) differ = 1'b1;
      slot = 0;
      framing = 1'b0;
      if (!differ) return 1'b0;
      for (int i = 0; i < len; i++) shown_tag[i] = frame_bytes[i];
      shown_len = len;
      ticks_since_report = '0;
      n_reports++;
      if (len == 0) begin
        n_empty++;
        owe(1, 1, 0, '0, '0, 1, 1);
      end else begin
        for (int i = 0; i < len; i++)
          owe(1, 1, 1, frame_bytes[i], i[4:0], i == len - 1, i == len - 1);
      end
      return 1'b1;
    endfunction

    function void absorb_item(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] b);
      bit open;
      open = gate_open();
      n_items++;
      case (cmd)
        CMD_TICK: begin
          if (ticks_since_report != TICK_MAX) ticks_since_report++;
          owe(0, 0, 0, '0, '0, 1, 0);
        end
        CMD_IDLE: begin
          if (open) shown_len = 0;
          owe(0, 0, 0, '0, '0, 1, 0);
        end
        CMD_BYTE: begin
          if (!open) begin
            n_refused++;
            owe(0, 0, 0, '0, '0, 1, 0);
          end else begin
            if (active_enable) active = 1'b1;
            if (b == CHAR_ETX) begin
              if (!close_tag()) owe(1, 0, 0, '0, '0, 1, 0);
            end else begin
              if (b == CHAR_STX) begin
                framing = 1'b1;
                slot = 0;
              end else if (framing && b != CHAR_LF && b != CHAR_CR) begin
                frame_bytes[slot] = b;
                slot = (slot == SLOTS - 1) ? 5'd0 : slot + 5'd1;
              end
              owe(1, 0, 0, '0, '0, 1, 0);
            end
          end
        end
        default: owe(0, 0, 0, '0, '0, 1, 0);
      endcase
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("MISMATCH: %s", msg);
    endtask

    task check_field(string name, logic [BYTE_W-1:0] got, logic [BYTE_W-1:0] want);
      if (got !== want)
        report_mismatch($sformatf("result %0d field %s: got %0h, want %0h",
                                  n_results, name, got, want));
    endtask

    task check_result(tag_result_t got);
      tag_result_t want;
      n_results++;
      if (owed.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing owed", n_results));
        return;
      end
      want = owed.pop_front();
      check_field("byte_taken", got.byte_taken, want.byte_taken);
      check_field("new_tag", got.new_tag, want.new_tag);
      check_field("char_valid", got.char_valid, want.char_valid);
      check_field("tag_char", got.tag_char, want.tag_char);
      check_field("char_position", got.char_position, want.char_position);
      check_field("last", got.last, want.last);
      check_field("reader_reset_pulse", got.reader_reset_pulse, want.reader_reset_pulse);
      check_field("activity", got.activity, want.activity);
    endtask

    task close_out();
      if (owed.size() != 0)
        report_mismatch($sformatf("%0d owed results never arrived", owed.size()));
    endtask
  endclass

  logic clk;
  logic rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  rtfd_in_if            req_if ();
  rtfd_out_if #(.POS_W(5)) rsp_if ();

  rfid_tag_frame_deduplicator #(.TAG_SLOTS(SLOTS)) dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_if),
    .rsp       (rsp_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tag_report_tracker tracker = new();

  int          send_idle_pct;
  int          recv_idle_pct;
  int          recv_hold;
  int unsigned quiet_cycles;
  tag_bytes_t  last_body;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: stall at random, or hold ready low for a counted stretch when asked.
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (recv_hold > 0) begin
        recv_hold--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Check results before noting inputs, so that a result arriving on the same edge as
  // an item cannot hide behind that item's expectation.
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_if.valid && rsp_if.ready)
        tracker.check_result({rsp_if.byte_taken, rsp_if.new_tag, rsp_if.char_valid,
                              rsp_if.tag_char, rsp_if.char_position, rsp_if.last,
                              rsp_if.reader_reset_pulse, rsp_if.activity});
      if (req_if.valid && req_if.ready)
        tracker.absorb_item(req_if.command, req_if.rx_byte);
    end
  end

  // Watchdog: count edges where neither channel moves an item.
  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: %0d cycles without a handshake", quiet_cycles);
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one item; idle first at the sender's rate, then hold it until accepted.
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      req_if.valid <= 1'b0;
    end
    @(negedge clk);
    req_if.valid   <= 1'b1;
    req_if.command <= cmd;
    req_if.rx_byte <= b;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
  endtask

  task automatic send_tick();
    send_item(CMD_TICK, 8'($urandom_range(255)));
  endtask

  task automatic send_frame(input tag_bytes_t body);
    send_item(CMD_BYTE, CHAR_STX);
    foreach (body[i]) send_item(CMD_BYTE, body[i]);
    send_item(CMD_BYTE, CHAR_ETX);
  endtask

  // Drop valid and wait until every owed result has come back.
  task automatic wait_all_results();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    tracker.configure(idx, data);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly printable tag characters, with line endings and arbitrary bytes mixed in.
  function automatic logic [BYTE_W-1:0] random_char();
    case ($urandom_range(15))
      0:       return 8'($urandom_range(255));
      1:       return $urandom_range(1) ? CHAR_CR : CHAR_LF;
      default: return 8'($urandom_range(8'h20, 8'h7E));
    endcase
  endfunction

  // Well-formed frame; often a repeat of the last tag so the duplicate filter gets work.
  task automatic random_frame();
    tag_bytes_t body;
    int         n;
    if (last_body.size() > 0 && $urandom_range(99) < 30) begin
      body = last_body;
    end else begin
      n = ($urandom_range(9) == 0) ? $urandom_range(17, 24) : $urandom_range(0, 10);
      repeat (n) body.push_back(random_char());
    end
    last_body = body;
    send_frame(body);
  endtask

  task automatic run_random(input int count);
    int                done;
    int                k;
    logic [CMD_W-1:0]  cmd;
    done = 0;
    while (done < count) begin
      case ($urandom_range(19))
        0, 1, 2: begin
          // noise: any command, any byte
          cmd = CMD_W'($urandom_range(3));
          send_item(cmd, 8'($urandom_range(255)));
          if (cmd != CMD_UNUSED) done++;
        end
        3, 4: begin
          // broken frame: opened, never closed
          send_item(CMD_BYTE, CHAR_STX);
          k = $urandom_range(1, 6);
          repeat (k) send_item(CMD_BYTE, random_char());
          done += k + 1;
        end
        5: begin
          k = $urandom_range(1, 3);
          repeat (k) send_tick();
          done += k;
        end
        default: begin
          // usually wait out the holdoff; sometimes run into it and get refused
          if ($urandom_range(4) != 0) begin
            while (!tracker.gate_open()) begin
              send_tick();
              done++;
            end
          end
          random_frame();
          done += last_body.size() + 2;
          if ($urandom_range(3) == 0) begin
            send_item(CMD_IDLE, 8'($urandom_range(255)));
            done++;
          end
        end
      endcase
    end
  endtask

  initial begin
    tag_bytes_t body;
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    req_if.valid   = 1'b0;
    req_if.command = CMD_TICK;
    req_if.rx_byte = '0;
    send_idle_pct  = 7;
    recv_idle_pct  = 47;
    recv_hold      = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: holdoff active, so a byte is refused and an idle poll does nothing.
    send_item(CMD_BYTE, 8'hFF);
    send_item(CMD_IDLE, 8'h00);
    send_item(CMD_UNUSED, 8'hAA);
    send_tick();
    wait_all_results();

    // Zero holdoff; activity off by bit 0 with the upper bits set; spare indexes ignored.
    write_reg(CFG_HOLDOFF, 16'h0000);
    write_reg(CFG_ACTIVITY, 16'hFFFE);
    write_reg(CFG_SPARE_2, 16'hFFFF);
    write_reg(CFG_SPARE_3, 16'h1234);

    // Byte outside a frame is taken and dropped; lone ETX closes an empty tag.
    send_item(CMD_BYTE, CHAR_NUL);
    send_item(CMD_BYTE, CHAR_ETX);
    // "AB" with CR and LF skipped: first report, then holdoff refuses a byte.
    body = '{8'h41, CHAR_CR, CHAR_LF, 8'h42};
    send_frame(body);
    send_item(CMD_BYTE, 8'h7A);
    send_item(CMD_IDLE, 8'h00);
    send_tick();
    wait_all_results();

    write_reg(CFG_ACTIVITY, 16'h0001);
    // Same tag again: no report. Then an empty tag differs from "AB".
    body = '{8'h41, 8'h42};
    send_frame(body);
    body = {};
    send_frame(body);
    send_tick();
    // NUL cuts the tag to "A"; an idle poll past holdoff forgets it, so it reports again.
    body = '{8'h41, CHAR_NUL, 8'hFF};
    send_frame(body);
    send_tick();
    send_item(CMD_IDLE, 8'h00);
    body = '{8'h41};
    send_frame(body);
    send_tick();
    // Longest tag: nineteen characters, the most results one item can cause.
    body = '{8'hFF, 8'h80, 8'h01};
    for (int i = 0; i < 16; i++) body.push_back(8'h61 + 8'(i));
    send_frame(body);
    send_tick();
    wait_all_results();

    // Random traffic, sender idling lightly, receiver heavily; pause once mid-way.
    write_reg(CFG_HOLDOFF, 16'd2);
    run_random(45);
    wait_all_results();
    run_random(45);
    wait_all_results();

    send_idle_pct = 47;
    recv_idle_pct = 7;
    write_reg(CFG_HOLDOFF, 16'd5);
    write_reg(CFG_ACTIVITY, 16'h0000);
    run_random(95);
    wait_all_results();

    // No idling; hold the receiver off long enough that the block backs up its input.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(CFG_HOLDOFF, 16'd1);
    write_reg(CFG_ACTIVITY, 16'h0001);
    run_random(30);
    recv_hold = LONG_STALL;
    run_random(55);
    wait_all_results();

    // Largest holdoff: bytes are refused and an idle poll changes nothing.
    write_reg(CFG_HOLDOFF, 16'hFFFF);
    send_item(CMD_BYTE, 8'h5A);
    repeat (3) send_tick();
    send_item(CMD_IDLE, 8'h00);
    body = '{8'h5A, 8'hA5};
    send_frame(body);
    wait_all_results();
    repeat (50) @(posedge clk);

    tracker.close_out();
    $display("Covered %0d items (%0d bytes refused in holdoff), %0d results checked,",
             tracker.n_items, tracker.n_refused, tracker.n_results);
    $display("%0d tag reports (%0d of them empty), %0d mismatches.",
             tracker.n_reports, tracker.n_empty, tracker.errors);
    if (tracker.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
